// ===== design/kmfb_pkg.sv =====
// ----------------------------------------------------------------------------
// kmfb_pkg
// Shared types and codes of the keyed mailbox bank: request kinds, status
// codes, sequencer states and the request and response item structs.
// ----------------------------------------------------------------------------
package kmfb_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SEND   = 2'd1,
    OP_RECV   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_FREE  = 3'd1,
    STAT_NOT_USED = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_META,
    S_RING
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] mailbox_key;
    logic [3:0]         mailbox_index;
    logic signed [31:0] message_in;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [3:0]         mailbox_found;
    logic signed [31:0] message_out;
  } rsp_t;

endpackage

// ===== design/kmfb_ram.sv =====
// ----------------------------------------------------------------------------
// kmfb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kmfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/keyed_mailbox_fifo_bank_core.sv =====
// ----------------------------------------------------------------------------
// keyed_mailbox_fifo_bank_core
// Bank of keyed mailboxes, each with a ring of message words; handles create,
// send and receive requests one at a time under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start_i; the item is taken at the
//   rising edge where start_i is high and busy_o is low. busy_o stays high
//   while the item is at work.
//   Response channel: done_o pulses for one cycle with rsp_o; the receiver
//   cannot stall it and must take the item in that cycle.
//   States, from the accepting edge to the done_o cycle:
//     bad send or receive (op code, index, mailbox not in use): S_DECODE only
//     send: S_DECODE, S_META; receive: S_DECODE, S_META, S_RING if not empty
//     create: S_DECODE, then S_SCAN_RD and S_SCAN_CMP for mailboxes 0 to j when
//     mailbox j matches, else for all, claiming a free one if there is one.
//   busy_o drops in the done_o cycle, so a new item can be taken at the edge
//   that ends it. Create time is set by the shared key comparator, which
//   walks the key RAM one mailbox at a time, with a registered read in
//   S_SCAN_RD and a compare in S_SCAN_CMP for each mailbox.
//   Reset clears the in-use flags and the sequencer; key, ring pointer and
//   ring word RAMs need no clearing, since a mailbox is only touched after a
//   create has claimed it and zeroed its ring pointers.
// ----------------------------------------------------------------------------
module keyed_mailbox_fifo_bank_core
  import kmfb_pkg::*;
#(
  parameter int MAILBOX_COUNT = 16,
  parameter int RING_DEPTH    = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int MB_W   = $clog2(MAILBOX_COUNT);
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int META_W = 2 * PTR_W + CNT_W;
  localparam int ADDR_W = $clog2(MAILBOX_COUNT * RING_DEPTH);
  localparam logic [ADDR_W-1:0] RD_A     = ADDR_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(RING_DEPTH);
  localparam logic [MB_W-1:0]   MB_LAST  = MB_W'(MAILBOX_COUNT - 1);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Sequencer and item registers
  state_e                   state_q, state_d;
  req_t                     req_q;
  logic [MB_W-1:0]          idx_q;
  logic                     in_range_q;
  logic [MB_W-1:0]          scan_q;
  logic                     free_vld_q;
  logic [MB_W-1:0]          free_idx_q;
  logic [MAILBOX_COUNT-1:0] used_q;
  rsp_t                     rsp_q, rsp_d;
  logic                     done_q, done_d;

  logic accept;
  logic req_bad;
  logic key_hit;
  logic scan_last;

  // Memory ports
  logic [31:0]       key_rd;
  logic              claim_en;
  logic [MB_W-1:0]   claim_idx;
  logic              meta_we;
  logic [MB_W-1:0]   meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rd;
  logic              ring_we;
  logic [ADDR_W-1:0] ring_waddr;
  logic [ADDR_W-1:0] ring_raddr;
  logic [31:0]       ring_rd;

  logic [PTR_W-1:0]  rd_rp;
  logic [PTR_W-1:0]  rd_wp;
  logic [CNT_W-1:0]  rd_cnt;
  logic [ADDR_W-1:0] ring_base;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  // Reject a send or receive on a bad op code, an index past the bank, or an
  // idle mailbox.
  assign req_bad = !(req_q.op inside {OP_SEND, OP_RECV}) ||
                   !in_range_q || !used_q[idx_q];

  assign key_hit   = used_q[scan_q] && (key_rd == req_q.mailbox_key);
  assign scan_last = (scan_q == MB_LAST);

  assign rd_rp     = meta_rd[CNT_W + PTR_W +: PTR_W];
  assign rd_wp     = meta_rd[CNT_W +: PTR_W];
  assign rd_cnt    = meta_rd[0 +: CNT_W];
  assign ring_base = ADDR_W'(idx_q) * RD_A;

  // Claim the lowest free mailbox seen during the scan, or the last one
  assign claim_idx  = free_vld_q ? free_idx_q : scan_q;
  assign meta_waddr = claim_en ? claim_idx : idx_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (req_q.op == OP_CREATE) begin
          state_d = S_SCAN_RD;
        end else if (req_bad) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_META;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_d = (key_hit || scan_last) ? S_IDLE : S_SCAN_RD;
      end
      S_META: begin
        if (req_q.op == OP_RECV && rd_cnt != '0) begin
          state_d = S_RING;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RING: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath controls and the response
  // --------------------------------------------------------------------------
  always_comb begin
    rsp_d      = '0;
    done_d     = 1'b0;
    claim_en   = 1'b0;
    meta_we    = 1'b0;
    meta_wdata = '0;
    ring_we    = 1'b0;
    ring_waddr = ring_base + ADDR_W'(rd_wp);
    ring_raddr = ring_base + ADDR_W'(rd_rp);
    case (state_q)
      S_DECODE: begin
        if (req_q.op != OP_CREATE && req_bad) begin
          done_d       = 1'b1;
          rsp_d.status = STAT_NOT_USED;
        end
      end
      S_SCAN_CMP: begin
        if (key_hit) begin
          done_d              = 1'b1;
          rsp_d.status        = STAT_OK;
          rsp_d.mailbox_found = 4'(scan_q);
        end else if (scan_last) begin
          done_d = 1'b1;
          if (free_vld_q || !used_q[scan_q]) begin
            // Claim: take the key and empty the ring
            claim_en            = 1'b1;
            meta_we             = 1'b1;
            rsp_d.status        = STAT_OK;
            rsp_d.mailbox_found = 4'(claim_idx);
          end else begin
            rsp_d.status = STAT_NO_FREE;
          end
        end
      end
      S_META: begin
        if (req_q.op == OP_SEND) begin
          done_d = 1'b1;
          if (rd_cnt == CNT_FULL) begin
            rsp_d.status = STAT_FULL;
          end else begin
            ring_we      = 1'b1;
            meta_we      = 1'b1;
            meta_wdata   = {rd_rp, next_slot(rd_wp), rd_cnt + CNT_W'(1)};
            rsp_d.status = STAT_OK;
          end
        end else if (rd_cnt == '0) begin
          done_d       = 1'b1;
          rsp_d.status = STAT_EMPTY;
        end else begin
          // Word comes back next cycle; advance the read pointer now
          meta_we    = 1'b1;
          meta_wdata = {next_slot(rd_rp), rd_wp, rd_cnt - CNT_W'(1)};
        end
      end
      S_RING: begin
        done_d            = 1'b1;
        rsp_d.status      = STAT_OK;
        rsp_d.message_out = ring_rd;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      used_q     <= '0;
      scan_q     <= '0;
      free_vld_q <= 1'b0;
      free_idx_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (accept) begin
        scan_q     <= '0;
        free_vld_q <= 1'b0;
      end else if (state_q == S_SCAN_CMP && !key_hit && !scan_last) begin
        scan_q <= scan_q + MB_W'(1);
        if (!used_q[scan_q] && !free_vld_q) begin
          free_vld_q <= 1'b1;
          free_idx_q <= scan_q;
        end
      end
      if (claim_en) begin
        used_q[claim_idx] <= 1'b1;
      end
    end
  end

  // Hold the item and the response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_i;
      idx_q      <= MB_W'(req_i.mailbox_index);
      in_range_q <= (9'(req_i.mailbox_index) < 9'(MAILBOX_COUNT));
    end
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  kmfb_ram #(
    .WIDTH (32),
    .DEPTH (MAILBOX_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (claim_en),
    .waddr_i (claim_idx),
    .wdata_i (req_q.mailbox_key),
    .raddr_i (scan_q),
    .rdata_o (key_rd)
  );

  kmfb_ram #(
    .WIDTH (META_W),
    .DEPTH (MAILBOX_COUNT)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (idx_q),
    .rdata_o (meta_rd)
  );

  kmfb_ram #(
    .WIDTH (32),
    .DEPTH (MAILBOX_COUNT * RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (req_q.message_in),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rd)
  );

endmodule

// ===== design/kmfb_checker.sv =====
// ----------------------------------------------------------------------------
// kmfb_checker
// Port-level checks of the mailbox bank, bound to the top level.
// ----------------------------------------------------------------------------
module kmfb_checker
  import kmfb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic done_o,
  input rsp_t rsp_o
);

  // An accepted item always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  // Every item passes through S_DECODE before its strobe, so strobes never touch
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status == STAT_OK) || (rsp_o.status == STAT_NO_FREE) ||
               (rsp_o.status == STAT_NOT_USED) || (rsp_o.status == STAT_FULL) ||
               (rsp_o.status == STAT_EMPTY))
    else $error("undefined status code");

  // A failed request carries no mailbox and no message
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != STAT_OK) |->
      (rsp_o.mailbox_found == '0) && (rsp_o.message_out == '0))
    else $error("failed request carries payload");

endmodule

bind keyed_mailbox_fifo_bank_core kmfb_checker u_kmfb_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

// ===== bench/keyed_mailbox_fifo_bank_core_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_mailbox_fifo_bank_core_tb
// Drives create, send and receive requests into the mailbox bank and checks
// every response against a cycle-free model of the bank kept in this bench.
// Requests come from a queue that is filled up front: a short directed run
// first, then random segments of send bursts, drain bursts, key lookups and
// noise. The request side idles at random, apart from one long steady stretch.
// ----------------------------------------------------------------------------
module keyed_mailbox_fifo_bank_core_tb;
  import kmfb_pkg::*;

  localparam int MAILBOX_COUNT = 16;
  localparam int RING_DEPTH    = 8;

  // Request code the package leaves unnamed; the bank must reject it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int TOTAL_ITEMS  = 1050;
  localparam int KEY_POOL     = 24;
  localparam int IDLE_PERCENT = 30;
  localparam int STEADY_FIRST = 400;
  localparam int STEADY_LAST  = 650;
  // Longest create walks all mailboxes.
  localparam int DRAIN_CYCLES = 4 * MAILBOX_COUNT;
  localparam int RUN_LIMIT    = 8_000_000;
  localparam int NO_SLOT      = -1;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  req_t pending_requests[$];
  rsp_t expected_responses[$];
  rsp_t oldest_response;
  logic item_taken;
  int   issued_count;
  int   mismatch_count;

  // Bank image: flags, keys, rings and their pointers.
  logic        box_used [MAILBOX_COUNT];
  logic [31:0] box_key  [MAILBOX_COUNT];
  logic [31:0] box_ring [MAILBOX_COUNT][RING_DEPTH];
  logic [2:0]  box_rd   [MAILBOX_COUNT];
  logic [2:0]  box_wr   [MAILBOX_COUNT];
  logic [3:0]  box_fill [MAILBOX_COUNT];

  logic [31:0] key_pool [KEY_POOL];

  keyed_mailbox_fifo_bank_core #(
    .MAILBOX_COUNT(MAILBOX_COUNT),
    .RING_DEPTH   (RING_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [2:0] ring_next(logic [2:0] ptr);
    return (ptr == 3'(RING_DEPTH - 1)) ? 3'd0 : ptr + 3'd1;
  endfunction

  // Apply one request to the bank image and return the response it earns.
  function automatic rsp_t mailbox_response(req_t r);
    rsp_t res;
    int   slot;
    int   box;
    res.status        = STAT_OK;
    res.mailbox_found = '0;
    res.message_out   = '0;
    box               = int'(r.mailbox_index);
    if (r.op == OP_CREATE) begin
      slot = NO_SLOT;
      for (int i = 0; i < MAILBOX_COUNT; i++) begin
        if (slot == NO_SLOT && box_used[i] && box_key[i] == r.mailbox_key) slot = i;
      end
      if (slot == NO_SLOT) begin
        // No key match: claim the lowest free mailbox and empty its ring.
        for (int i = 0; i < MAILBOX_COUNT; i++) begin
          if (slot == NO_SLOT && !box_used[i]) slot = i;
        end
        if (slot != NO_SLOT) begin
          box_used[slot] = 1'b1;
          box_key[slot]  = r.mailbox_key;
          box_rd[slot]   = '0;
          box_wr[slot]   = '0;
          box_fill[slot] = '0;
        end
      end
      if (slot == NO_SLOT) res.status = STAT_NO_FREE;
      else res.mailbox_found = 4'(slot);
    end else if (r.op == OP_UNUSED || box >= MAILBOX_COUNT || !box_used[box]) begin
      res.status = STAT_NOT_USED;
    end else if (r.op == OP_SEND) begin
      if (box_fill[box] >= 4'(RING_DEPTH)) begin
        res.status = STAT_FULL;
      end else begin
        box_ring[box][box_wr[box]] = r.message_in;
        box_wr[box]   = ring_next(box_wr[box]);
        box_fill[box] = box_fill[box] + 4'd1;
      end
    end else if (box_fill[box] == '0) begin
      res.status = STAT_EMPTY;
    end else begin
      res.message_out = box_ring[box][box_rd[box]];
      box_rd[box]     = ring_next(box_rd[box]);
      box_fill[box]   = box_fill[box] - 4'd1;
    end
    return res;
  endfunction

  function automatic void queue_request(logic [1:0] op, logic [31:0] key,
                                        logic [3:0] index, logic [31:0] message);
    req_t r;
    r.op            = op;
    r.mailbox_key   = key;
    r.mailbox_index = index;
    r.message_in    = message;
    pending_requests.push_back(r);
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: hold the current item until taken, then advance or idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || item_taken)) begin
      if (pending_requests.size() != 0 &&
          !((issued_count < STEADY_FIRST || issued_count >= STEADY_LAST) &&
            $urandom_range(99) < IDLE_PERCENT)) begin
        req_i        <= pending_requests.pop_front();
        start_i      <= 1'b1;
        issued_count <= issued_count + 1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: retire the finished response first, then log a newly taken item,
  // since busy_o drops in the done cycle and both can land on one edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: response with nothing pending, expected none, got %h",
                   $time, rsp_o);
          mismatch_count++;
        end else begin
          oldest_response = expected_responses.pop_front();
          check_field("status", oldest_response.status, rsp_o.status);
          check_field("mailbox_found", oldest_response.mailbox_found,
                      rsp_o.mailbox_found);
          check_field("message_out", oldest_response.message_out, rsp_o.message_out);
        end
      end
      if (start_i && !busy_o) expected_responses.push_back(mailbox_response(req_i));
      item_taken <= start_i && !busy_o;
    end
  end

  initial begin
    int kind;
    int burst;
    int index;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    req_i          = '0;
    item_taken     = 1'b0;
    issued_count   = 0;
    mismatch_count = 0;
    for (int i = 0; i < MAILBOX_COUNT; i++) begin
      box_used[i] = 1'b0;
      box_key[i]  = '1;
      box_rd[i]   = '0;
      box_wr[i]   = '0;
      box_fill[i] = '0;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0000_0000;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

    // Directed: rejects on an empty bank, key extremes, a lookup hit,
    // empty and full rings, FIFO order and the unused request code.
    queue_request(OP_SEND, '0, 4'd0, 32'h1234_5678);
    queue_request(OP_RECV, '1, 4'd15, '1);
    queue_request(OP_UNUSED, '1, 4'd15, '1);
    queue_request(OP_CREATE, 32'h8000_0000, 4'd0, '0);
    queue_request(OP_CREATE, 32'h7fff_ffff, 4'd15, '1);
    queue_request(OP_CREATE, 32'h8000_0000, 4'd7, '0);
    queue_request(OP_RECV, '0, 4'd0, '0);
    queue_request(OP_SEND, '0, 4'd0, 32'h8000_0000);
    queue_request(OP_SEND, '0, 4'd0, 32'h7fff_ffff);
    queue_request(OP_SEND, '0, 4'd0, 32'h0000_0000);
    queue_request(OP_SEND, '0, 4'd0, 32'hffff_ffff);
    repeat (4) queue_request(OP_SEND, '0, 4'd0, $urandom);
    queue_request(OP_SEND, '0, 4'd0, 32'hdead_beef);
    queue_request(OP_RECV, '0, 4'd0, '0);
    queue_request(OP_RECV, '0, 4'd0, '0);
    queue_request(OP_UNUSED, '0, 4'd0, '0);
    queue_request(OP_CREATE, 32'hffff_ffff, 4'd0, '0);
    queue_request(OP_CREATE, 32'h0000_0000, 4'd0, '0);
    queue_request(OP_CREATE, 32'h7fff_ffff, 4'd0, '0);

    // Random: mostly bursts aimed at one mailbox so rings fill, wrap and drain;
    // pool keys hit earlier mailboxes, fresh keys push the bank to full.
    while (pending_requests.size() < TOTAL_ITEMS) begin
      kind  = $urandom_range(99);
      burst = $urandom_range(1, 10);
      index = ($urandom_range(3) != 0) ? $urandom_range(7) : $urandom_range(15);
      if (kind < 30) begin
        repeat (burst) queue_request(OP_SEND, $urandom, 4'(index), $urandom);
      end else if (kind < 55) begin
        repeat (burst) queue_request(OP_RECV, $urandom, 4'(index), $urandom);
      end else if (kind < 75) begin
        repeat (burst) begin
          queue_request($urandom_range(1) ? OP_SEND : OP_RECV, $urandom, 4'(index),
                        $urandom);
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 3)) begin
          queue_request(OP_CREATE, key_pool[$urandom_range(KEY_POOL - 1)],
                        4'($urandom), $urandom);
        end
      end else if (kind < 94) begin
        queue_request(OP_CREATE, $urandom, 4'($urandom), $urandom);
      end else begin
        queue_request(OP_UNUSED, $urandom, 4'($urandom), $urandom);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_requests.size() != 0 || start_i || expected_responses.size() != 0) begin
      @(posedge clk_i);
    end
    // Hold a while longer to catch any stray response.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("keyed_mailbox_fifo_bank_core_tb: done, clean");
    end else begin
      $display("keyed_mailbox_fifo_bank_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("%0t: timeout", $time);
    $display("keyed_mailbox_fifo_bank_core_tb: done, errors");
    $finish;
  end

endmodule

// ===== keyed_mailbox_fifo_bank_core.f =====
design/kmfb_pkg.sv
design/kmfb_ram.sv
design/keyed_mailbox_fifo_bank_core.sv
design/kmfb_checker.sv
bench/keyed_mailbox_fifo_bank_core_tb.sv
